@@ rtl/core/sptrle_pkg.sv @@
// ----------------------------------------------------------------------------
// sptrle_pkg
// Shared constants and types of the sprite transparency run-length encoder.
// ----------------------------------------------------------------------------
package sptrle_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int PIX_W     = 32;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = $clog2(MAX_WIDTH);
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Output word kinds.
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TERM   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH        = 2'd1;

    localparam logic [LEN_W-1:0] LINE_WIDTH_RESET = LEN_W'(32);
    localparam logic [LEN_W-1:0] MIN_LINE_WIDTH   = LEN_W'(2);
    localparam logic [LEN_W-1:0] MAX_LINE_WIDTH   = LEN_W'(MAX_WIDTH);

    // One classified pixel: what the back end has to store and emit for it.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             hdr_en;     // header ahead of the first run change
        logic             hdr_val;
        logic             lena_en;    // length of the run that just closed
        logic [LEN_W-1:0] lena;
        logic [LEN_W-1:0] dumpa;      // pixels of that run to replay
        logic             wordb_en;   // end-of-line header or length
        logic             wordb_hdr;
        logic [LEN_W-1:0] wordb_val;
        logic [LEN_W-1:0] dumpb;
        logic             term_en;
        logic             line_end;
    } cmd_t;

endpackage

@@ rtl/core/sprite_transparency_rle_encoder_core.sv @@
// ----------------------------------------------------------------------------
// sprite_transparency_rle_encoder_core
// Encodes 32-bit pixel scanlines into opaque and transparent runs.
// ----------------------------------------------------------------------------
// Path: a pixel's command is written into the queue, fetched into the back end's
// command register, and its first word is then loaded into the output register.
// The back end fetches a command only while idle and then emits its words in
// turn, holding while the output stalls, so a quiet pixel costs only a fetch.
// Reset: synchronous and active low; it clears the line state, the queue and
// the output valid flag, but not the run buffer, which is written before read.
// ----------------------------------------------------------------------------
module sprite_transparency_rle_encoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sptrle_pkg::PIX_W-1:0]      s_pixel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sptrle_pkg::PIX_W-1:0]      m_out_word,
    output logic [sptrle_pkg::KIND_W-1:0]     m_word_kind,
    output logic                              m_line_done,
    output logic                              m_burst_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sptrle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sptrle_pkg::PIX_W-1:0]      cfg_data
);
    import sptrle_pkg::*;

    logic [PIX_W-1:0] color_reg;
    logic [LEN_W-1:0] width_reg;

    logic             push;
    cmd_t             push_cmd;
    logic             pop;
    cmd_t             head;
    logic             fifo_empty;
    logic             fifo_full;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [PIX_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [PIX_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= '0;
            width_reg <= LINE_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TRANSPARENT_COLOR: color_reg <= cfg_data;
                REG_LINE_WIDTH:        width_reg <= cfg_data[LEN_W-1:0];
                default:               ;
            endcase
        end
    end

    sptrle_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel           (s_pixel),
        .transparent_color (color_reg),
        .line_width        (width_reg),
        .fifo_full         (fifo_full),
        .push              (push),
        .push_cmd          (push_cmd)
    );

    sptrle_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    sptrle_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_run_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    sptrle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_head    (head),
        .fifo_empty   (fifo_empty),
        .pop          (pop),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_word   (m_out_word),
        .m_word_kind  (m_word_kind),
        .m_line_done  (m_line_done),
        .m_burst_last (m_burst_last)
    );

endmodule

@@ rtl/core/sptrle_ram.sv @@
// ----------------------------------------------------------------------------
// sptrle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sptrle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sptrle_front.sv @@
// ----------------------------------------------------------------------------
// sptrle_front
// Accepts pixels, tracks line and run position, and turns each pixel into
// one command for the back end.
// ----------------------------------------------------------------------------
module sptrle_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sptrle_pkg::PIX_W-1:0]  s_pixel,
    input  logic [sptrle_pkg::PIX_W-1:0]  transparent_color,
    input  logic [sptrle_pkg::LEN_W-1:0]  line_width,
    input  logic                          fifo_full,
    output logic                          push,
    output sptrle_pkg::cmd_t              push_cmd
);
    import sptrle_pkg::*;

    logic [LEN_W-1:0] column_reg, column_next;
    logic             run_opaque_reg, run_opaque_next;
    logic [LEN_W-1:0] run_length_reg, run_length_next;
    logic             first_opaque_reg, first_opaque_next;
    logic             header_sent_reg, header_sent_next;

    logic             opaque;
    logic             change;
    logic             line_end;
    logic [LEN_W-1:0] width_eff;
    logic [LEN_W-1:0] rl_after;
    logic             ro_start, fo_start, hs_start;
    logic [LEN_W-1:0] rl_start;

    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        opaque = (s_pixel != transparent_color);

        if (line_width < MIN_LINE_WIDTH) begin
            width_eff = MIN_LINE_WIDTH;
        end else if (line_width > MAX_LINE_WIDTH) begin
            width_eff = MAX_LINE_WIDTH;
        end else begin
            width_eff = line_width;
        end

        // The first pixel of a line opens a fresh run.
        if (column_reg == '0) begin
            fo_start = opaque;
            ro_start = opaque;
            rl_start = '0;
            hs_start = 1'b0;
        end else begin
            fo_start = first_opaque_reg;
            ro_start = run_opaque_reg;
            rl_start = run_length_reg;
            hs_start = header_sent_reg;
        end

        change = (column_reg != '0) && (opaque != run_opaque_reg);

        push_cmd         = '0;
        push_cmd.pixel   = s_pixel;
        push_cmd.hdr_en  = change && !hs_start;
        push_cmd.hdr_val = fo_start;
        push_cmd.lena_en = change;
        push_cmd.lena    = rl_start;
        push_cmd.dumpa   = (change && ro_start) ? rl_start : '0;

        first_opaque_next = fo_start;
        run_opaque_next   = ro_start;
        header_sent_next  = hs_start;
        if (change) begin
            run_opaque_next  = opaque;
            rl_start         = '0;
            header_sent_next = 1'b1;
        end

        push_cmd.wr_en  = opaque && (rl_start < MAX_LINE_WIDTH);
        push_cmd.wr_idx = rl_start[IDX_W-1:0];
        rl_after        = (rl_start < MAX_LINE_WIDTH) ? rl_start + LEN_W'(1) : rl_start;
        run_length_next = rl_after;

        line_end = ({1'b0, column_reg} + (LEN_W+1)'(1)) >= {1'b0, width_eff};
        push_cmd.line_end = line_end;

        if (line_end) begin
            if (!header_sent_next) begin
                // The whole line is one run.
                push_cmd.wordb_en  = 1'b1;
                push_cmd.wordb_hdr = 1'b1;
                push_cmd.wordb_val = {{(LEN_W-2){1'b0}}, 1'b1, first_opaque_next};
                push_cmd.dumpb     = first_opaque_next ? rl_after : '0;
                header_sent_next   = 1'b1;
            end else begin
                push_cmd.wordb_en  = run_opaque_next;
                push_cmd.wordb_hdr = 1'b0;
                push_cmd.wordb_val = rl_after;
                push_cmd.dumpb     = run_opaque_next ? rl_after : '0;
                push_cmd.term_en   = 1'b1;
            end
            column_next = '0;
        end else begin
            column_next = column_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg       <= '0;
            run_opaque_reg   <= 1'b0;
            run_length_reg   <= '0;
            first_opaque_reg <= 1'b0;
            header_sent_reg  <= 1'b0;
        end else if (push) begin
            column_reg       <= column_next;
            run_opaque_reg   <= run_opaque_next;
            run_length_reg   <= run_length_next;
            first_opaque_reg <= first_opaque_next;
            header_sent_reg  <= header_sent_next;
        end
    end

`ifndef SYNTH
    a_run_within_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (column_reg != '0) |-> (run_length_reg <= column_reg))
        else $error("run length exceeds the pixels seen on this line");
    a_column_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg < MAX_LINE_WIDTH)
        else $error("column ran past the widest line");
    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_cmd.line_end |=> column_reg == '0)
        else $error("line end did not restart the column");
`endif

endmodule

@@ rtl/core/sptrle_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// sptrle_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sptrle_cmd_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sptrle_pkg::cmd_t push_cmd,
    input  logic             pop,
    output sptrle_pkg::cmd_t head,
    output logic             empty,
    output logic             full
);
    import sptrle_pkg::*;

    cmd_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("command pushed into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("command popped from an empty queue");
    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + FIFO_CNT_W'(1))
        else $error("queue count lost a transfer");
`endif

endmodule

@@ rtl/core/sptrle_back.sv @@
// ----------------------------------------------------------------------------
// sptrle_back
// Executes commands: stores opaque pixels into the run buffer and emits the
// header, length, pixel and terminator words through the output register.
// ----------------------------------------------------------------------------
module sptrle_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sptrle_pkg::cmd_t              fifo_head,
    input  logic                          fifo_empty,
    output logic                          pop,
    output logic                          ram_we,
    output logic [sptrle_pkg::IDX_W-1:0]  ram_waddr,
    output logic [sptrle_pkg::PIX_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [sptrle_pkg::IDX_W-1:0]  ram_raddr,
    input  logic [sptrle_pkg::PIX_W-1:0]  ram_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sptrle_pkg::PIX_W-1:0]  m_out_word,
    output logic [sptrle_pkg::KIND_W-1:0] m_word_kind,
    output logic                          m_line_done,
    output logic                          m_burst_last
);
    import sptrle_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_HDR   = 3'd1,
        ST_LENA  = 3'd2,
        ST_DUMPA = 3'd3,
        ST_WORDB = 3'd4,
        ST_DUMPB = 3'd5,
        ST_TERM  = 3'd6
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  m_word_reg, m_word_next;
    logic [KIND_W-1:0] m_kind_reg, m_kind_next;
    logic              m_done_reg, m_done_next;
    logic              m_last_reg, m_last_next;

    state_t            after;
    logic              out_free;
    logic              emit;
    logic              dump_more;
    logic              word_last;
    logic [PIX_W-1:0]  word;
    logic [KIND_W-1:0] kind;

    // Phases run in enum order; each is skipped when the command lacks it.
    function automatic state_t next_phase(state_t cur, cmd_t c);
        state_t n;
        n = ST_IDLE;
        if (cur < ST_TERM && c.term_en) n = ST_TERM;
        if (cur < ST_DUMPB && c.dumpb != '0) n = ST_DUMPB;
        if (cur < ST_WORDB && c.wordb_en) n = ST_WORDB;
        if (cur < ST_DUMPA && c.dumpa != '0) n = ST_DUMPA;
        if (cur < ST_LENA && c.lena_en) n = ST_LENA;
        if (cur < ST_HDR && c.hdr_en) n = ST_HDR;
        return n;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign ram_waddr = fifo_head.wr_idx;
    assign ram_wdata = fifo_head.pixel;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        m_kind_next  = m_kind_reg;
        m_done_next  = m_done_reg;
        m_last_next  = m_last_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        emit         = 1'b0;
        dump_more    = 1'b0;
        word         = '0;
        kind         = KIND_HEADER;
        after        = next_phase(state_reg, cmd_reg);

        unique case (state_reg)
            ST_IDLE: begin
                // A command never replays and stores in the same step, so the
                // store can go ahead at fetch time.
                if (!fifo_empty) begin
                    pop        = 1'b1;
                    ram_we     = fifo_head.wr_en;
                    cmd_next   = fifo_head;
                    state_next = next_phase(ST_IDLE, fifo_head);
                end
            end
            ST_HDR: begin
                word = {{(PIX_W-1){1'b0}}, cmd_reg.hdr_val};
                kind = KIND_HEADER;
                emit = out_free;
            end
            ST_LENA: begin
                word = {{(PIX_W-LEN_W){1'b0}}, cmd_reg.lena};
                kind = KIND_LENGTH;
                emit = out_free;
            end
            ST_DUMPA: begin
                word      = ram_rdata;
                kind      = KIND_PIXEL;
                dump_more = (LEN_W'(idx_reg) + LEN_W'(1)) != cmd_reg.dumpa;
                emit      = out_free;
            end
            ST_WORDB: begin
                word = {{(PIX_W-LEN_W){1'b0}}, cmd_reg.wordb_val};
                kind = cmd_reg.wordb_hdr ? KIND_HEADER : KIND_LENGTH;
                emit = out_free;
            end
            ST_DUMPB: begin
                word      = ram_rdata;
                kind      = KIND_PIXEL;
                dump_more = (LEN_W'(idx_reg) + LEN_W'(1)) != cmd_reg.dumpb;
                emit      = out_free;
            end
            ST_TERM: begin
                word = '0;
                kind = KIND_TERM;
                emit = out_free;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        word_last = !dump_more && (after == ST_IDLE);

        if (emit) begin
            m_valid_next = 1'b1;
            m_word_next  = word;
            m_kind_next  = kind;
            m_last_next  = word_last;
            m_done_next  = word_last && cmd_reg.line_end;
            if (dump_more) begin
                idx_next  = idx_reg + IDX_W'(1);
                ram_re    = 1'b1;
                ram_raddr = idx_reg + IDX_W'(1);
            end else begin
                state_next = after;
                // Prime the read of the first buffered pixel before the replay state begins.
                if (after == ST_DUMPA || after == ST_DUMPB) begin
                    idx_next = '0;
                    ram_re   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        m_word_reg <= m_word_next;
        m_kind_reg <= m_kind_next;
        m_done_reg <= m_done_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_word   = m_word_reg;
    assign m_word_kind  = m_kind_reg;
    assign m_line_done  = m_done_reg;
    assign m_burst_last = m_last_reg;

`ifndef SYNTH
    a_dump_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMPA) |-> (LEN_W'(idx_reg) < cmd_reg.dumpa))
        else $error("replay index ran past the closed run");
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> m_last_reg)
        else $error("line end flagged on a word that is not the last of its burst");
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && word_last |=> state_reg == ST_IDLE)
        else $error("back end kept working after the last word of a command");
`endif

endmodule

@@ tb/sv/tb_sprite_transparency_rle_encoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_sprite_transparency_rle_encoder_core
// Self-checking bench for the sprite transparency run-length encoder. A
// scoreboard class tracks the line state and predicts the words that each
// accepted pixel causes. Directed lines cover the format corners, random
// phases with changing settings and flow control cover the rest.
// ----------------------------------------------------------------------------
module tb_sprite_transparency_rle_encoder_core;
    import sptrle_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic [PIX_W-1:0]  word;
        logic [KIND_W-1:0] kind;
        logic              line_done;
        logic              burst_last;
    } rle_word_t;

    class rle_scoreboard;
        logic [PIX_W-1:0] key_color;
        logic [LEN_W-1:0] width_reg;
        logic [PIX_W-1:0] run_pix [MAX_WIDTH];
        logic [LEN_W-1:0] col;
        logic [LEN_W-1:0] run_len;
        logic             run_is_opaque;
        logic             line_first_opaque;
        logic             hdr_done;
        rle_word_t        burst[$];
        rle_word_t        pending_words[$];
        int               pixels_noted;
        int               words_checked;
        int               mismatches;

        function new();
            key_color         = '0;
            width_reg         = LINE_WIDTH_RESET;
            col               = '0;
            run_len           = '0;
            run_is_opaque     = 1'b0;
            line_first_opaque = 1'b0;
            hdr_done          = 1'b0;
            pixels_noted      = 0;
            words_checked     = 0;
            mismatches        = 0;
            foreach (run_pix[i]) run_pix[i] = '0;
        endfunction

        function int effective_width();
            if (width_reg < MIN_LINE_WIDTH) return MIN_LINE_WIDTH;
            if (width_reg > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
            return width_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
            if (idx == REG_TRANSPARENT_COLOR) key_color = data;
            else if (idx == REG_LINE_WIDTH) width_reg = data[LEN_W-1:0];
        endfunction

        function void emit(logic [PIX_W-1:0] word, logic [KIND_W-1:0] kind);
            rle_word_t w;
            w.word       = word;
            w.kind       = kind;
            w.line_done  = 1'b0;
            w.burst_last = 1'b0;
            burst.push_back(w);
        endfunction

        function void emit_run();
            for (int i = 0; i < run_len && i < MAX_WIDTH; i++) emit(run_pix[i], KIND_PIXEL);
        endfunction

        // Works out the words that one accepted pixel releases and queues them.
        function void note_pixel(logic [PIX_W-1:0] px);
            int        w;
            logic      opq;
            rle_word_t tail;
            w = effective_width();
            opq = (px != key_color);
            burst.delete();
            pixels_noted++;
            if (col == 0) begin
                line_first_opaque = opq;
                run_is_opaque     = opq;
                run_len           = '0;
                hdr_done          = 1'b0;
            end else if (opq != run_is_opaque) begin
                if (!hdr_done) begin
                    emit(PIX_W'(line_first_opaque), KIND_HEADER);
                    hdr_done = 1'b1;
                end
                emit(PIX_W'(run_len), KIND_LENGTH);
                if (run_is_opaque) emit_run();
                run_is_opaque = opq;
                run_len       = '0;
            end
            if (opq && run_len < MAX_WIDTH) run_pix[run_len[IDX_W-1:0]] = px;
            if (run_len < MAX_WIDTH) run_len = run_len + 1'b1;

            if (int'(col) + 1 >= w) begin
                if (!hdr_done) begin
                    // A line of one run: the header carries the single-run flag.
                    emit(PIX_W'(line_first_opaque) | PIX_W'(2), KIND_HEADER);
                    if (line_first_opaque) emit_run();
                    hdr_done = 1'b1;
                end else begin
                    if (run_is_opaque) begin
                        emit(PIX_W'(run_len), KIND_LENGTH);
                        emit_run();
                    end
                    emit('0, KIND_TERM);
                end
                tail = burst.pop_back();
                tail.line_done = 1'b1;
                burst.push_back(tail);
                col = '0;
            end else begin
                col = col + 1'b1;
            end

            if (burst.size() > 0) begin
                tail = burst.pop_back();
                tail.burst_last = 1'b1;
                burst.push_back(tail);
            end
            foreach (burst[i]) pending_words.push_back(burst[i]);
        endfunction

        function void fail_note(string msg);
            mismatches++;
            if (mismatches <= 10) $display("ERROR: %s", msg);
        endfunction

        function void check_word(rle_word_t got);
            rle_word_t exp;
            if (pending_words.size() == 0) begin
                fail_note($sformatf("unexpected word %h kind %0d done %0b last %0b",
                                    got.word, got.kind, got.line_done, got.burst_last));
                return;
            end
            exp = pending_words.pop_front();
            words_checked++;
            if (got !== exp)
                fail_note($sformatf({"word %0d: expected %h kind %0d done %0b last %0b, ",
                                     "got %h kind %0d done %0b last %0b"},
                                    words_checked, exp.word, exp.kind, exp.line_done,
                                    exp.burst_last, got.word, got.kind, got.line_done,
                                    got.burst_last));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel;
    logic                 m_valid;
    logic                 m_ready;
    logic [PIX_W-1:0]     m_out_word;
    logic [KIND_W-1:0]    m_word_kind;
    logic                 m_line_done;
    logic                 m_burst_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0]     cfg_data;

    rle_scoreboard sb = new();

    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int line_pos;
    bit hold_req;

    sprite_transparency_rle_encoder_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_word   (m_out_word),
        .m_word_kind  (m_word_kind),
        .m_line_done  (m_line_done),
        .m_burst_last (m_burst_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sprite_transparency_rle_encoder_core failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_pixel(s_pixel);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word({m_out_word, m_word_kind, m_line_done, m_burst_last});
    end

    // The receiver either stalls at random or sits out a long hold on request.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(input logic opaque,
                                                    input logic [PIX_W-1:0] key);
        logic [PIX_W-1:0] v;
        if (!opaque) return key;
        case ($urandom_range(7))
            0: v = key ^ (PIX_W'(1) << $urandom_range(PIX_W - 1));
            1: v = ~key;
            default: v = $urandom;
        endcase
        if (v == key) v = ~key;
        return v;
    endfunction

    // All driving tasks start and end just after a falling edge.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        line_pos = (line_pos + 1 >= sb.effective_width()) ? 0 : line_pos + 1;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Waits until every predicted word has gone out, then lets quiet pixels settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Runs of random length; a line may be all one run, short runs, or noise.
    task automatic send_runs(input int count);
        int   flip_pct;
        logic opq;
        flip_pct = 0;
        opq = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (line_pos == 0 || i == 0) begin
                case ($urandom_range(5))
                    0, 1: flip_pct = 0;
                    2: flip_pct = 10;
                    3: flip_pct = 25;
                    default: flip_pct = 50;
                endcase
                opq = $urandom_range(1);
            end else if ($urandom_range(99) < flip_pct) begin
                opq = ~opq;
            end
            send_pixel(pick_pixel(opq, sb.key_color));
        end
    endtask

    initial begin
        int                send_pcts [4];
        int                stall_pcts[4];
        logic [PIX_W-1:0]  widths    [NUM_PHASES];
        logic [PIX_W-1:0]  color;

        send_pcts  = '{0, 57, 0, 28};
        stall_pcts = '{0, 0, 57, 28};
        widths     = '{32'd32, 32'd2, 32'd63, 32'd7, 32'hA5A5_5FE8, 32'd13,
                       PIX_W'($urandom_range(2, 32)), 32'd33};

        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_pixel        = '0;
        m_ready        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_TRANSPARENT_COLOR;
        cfg_data       = '0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        hold_req       = 1'b0;
        line_pos       = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Two-pixel lines: all transparent, all opaque, and both mixed orders.
        write_reg(REG_TRANSPARENT_COLOR, '0);
        write_reg(REG_LINE_WIDTH, 32'd2);
        send_pixel('0);
        send_pixel('0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h1234_5678);
        send_pixel('0);
        send_pixel('0);
        send_pixel(32'h8000_0001);
        drain();

        // Alternating single-pixel runs with an all-ones key.
        write_reg(REG_TRANSPARENT_COLOR, 32'hFFFF_FFFF);
        write_reg(REG_LINE_WIDTH, 32'd5);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0001);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0002);
        send_pixel(32'hFFFF_FFFF);

        // Shrinking the width below the current column ends the line on the next pixel.
        send_pixel(32'h0000_0001);
        send_pixel(32'h0000_0002);
        send_pixel(32'hFFFF_FFFF);
        drain();
        write_reg(REG_LINE_WIDTH, 32'd3);
        send_pixel(32'h0000_0004);
        drain();

        // A key change in the middle of a line applies from the next pixel.
        write_reg(REG_LINE_WIDTH, 32'd4);
        send_pixel('0);
        send_pixel('0);
        drain();
        write_reg(REG_TRANSPARENT_COLOR, '0);
        send_pixel('0);
        send_pixel(32'h0000_0005);
        drain();

        // Widths below the minimum behave as the minimum.
        write_reg(REG_LINE_WIDTH, 32'd1);
        send_pixel(32'h0000_0007);
        send_pixel('0);
        drain();
        write_reg(REG_LINE_WIDTH, 32'hFFFF_FFC0);
        send_pixel('0);
        send_pixel(32'h0000_0009);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = send_pcts[p % 4];
            recv_stall_pct = stall_pcts[p % 4];
            case (p % 4)
                0: color = '0;
                1: color = 32'hFFFF_FFFF;
                default: color = $urandom;
            endcase
            write_reg(REG_TRANSPARENT_COLOR, color);
            write_reg(REG_LINE_WIDTH, widths[p]);
            send_runs($urandom_range(35, 45));
            drain();
        end

        // Long receiver hold while the sender keeps offering pixels.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_LINE_WIDTH, 32'd8);
        hold_req = 1'b1;
        send_runs(60);
        drain();

        $display("Sent %0d pixels over %0d random phases plus directed lines and a hold;",
                 sb.pixels_noted, NUM_PHASES);
        $display("checked %0d encoded words, %0d mismatches, %0d words never seen.",
                 sb.words_checked, sb.mismatches, sb.pending_words.size());
        if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
            $display("tb_sprite_transparency_rle_encoder_core passed");
        end else begin
            $display("tb_sprite_transparency_rle_encoder_core failed");
        end
        $finish;
    end

endmodule
